// File: rtl/xxhash_style_hash64_top_defines.svh
// ----------------------------------------------------------------------------
// xxhash_style_hash64_top_defines: assertion macros
// Implication checks on the rising clock edge, disabled under reset; empty
// bodies when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef XXHASH_STYLE_HASH64_TOP_DEFINES_SVH
`define XXHASH_STYLE_HASH64_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define XXH64_ASSERT_IMPL(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("xxh64: same-cycle check failed");
`define XXH64_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("xxh64: next-cycle check failed");
`else
`define XXH64_ASSERT_IMPL(label, trig, cond)
`define XXH64_ASSERT_NEXT(label, trig, cond)
`endif

`endif

// File: rtl/xxh64_pkg.sv
// ----------------------------------------------------------------------------
// xxh64_pkg: shared types and constants
// Hash primes, seed offsets, micro-operation codes and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package xxh64_pkg;

   localparam logic [63:0] K1 = 64'h9E37_79B1_85EB_CA87;
   localparam logic [63:0] K2 = 64'hC2B2_AE3D_27D4_EB4F;
   localparam logic [63:0] K3 = 64'h1656_67B1_9E37_79F9;
   localparam logic [63:0] K4 = 64'h85EB_CA77_C2B2_AE63;
   localparam logic [63:0] K5 = 64'h27D4_EB2F_1656_67C5;

   localparam logic [63:0] SEED_H  = K5;
   localparam logic [63:0] SEED_L0 = K5 + K1 + K2;
   localparam logic [63:0] SEED_L1 = K5 + K2;
   localparam logic [63:0] SEED_L2 = K5;
   localparam logic [63:0] SEED_L3 = K5 - K1;

   localparam logic [2:0] LAST_LANE = 3'd3;

   typedef enum logic [3:0] {
      MOP_LANE_A = 4'd0,
      MOP_LANE_B = 4'd1,
      MOP_MRG_A  = 4'd2,
      MOP_MRG_B  = 4'd3,
      MOP_MRG_C  = 4'd4,
      MOP_WRD_A  = 4'd5,
      MOP_WRD_B  = 4'd6,
      MOP_WRD_C  = 4'd7,
      MOP_BYT_A  = 4'd8,
      MOP_BYT_B  = 4'd9,
      MOP_AVA_A  = 4'd10,
      MOP_AVA_B  = 4'd11
   } mop_type;

   typedef struct packed {
      logic       capture;
      logic       seed;
      logic       mul_start;
      logic       write_back;
      logic       merge_init;
      logic       advance;
      logic       finish;
      logic       load_rsp;
      logic       rsp_zero;
      mop_type    mop;
      logic [2:0] idx;
   } dp_cmd_type;

   typedef struct packed {
      logic       len_zero;
      logic       in_chunk;
      logic       whole_word;
      logic       last_chunk;
      logic       last_word;
      logic [2:0] tail_count;
      logic       mul_done;
   } dp_stat_type;

   function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
      return (x << r) | (x >> (64 - r));
   endfunction

endpackage

// File: rtl/xxh64_mul.sv
// ----------------------------------------------------------------------------
// xxh64_mul: iterative 64x64 multiplier, low 64 bits of the product
// One registered 32x32 partial product per cycle, accumulated in the next;
// done pulses once the last partial product has been accumulated.
// ----------------------------------------------------------------------------
`include "xxhash_style_hash64_top_defines.svh"

module xxh64_mul
   import xxh64_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] product
);

   localparam logic [1:0] PH_LAST = 2'd3;

   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  phase_ff, phase_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [31:0] mul_x, mul_y;

   always_comb begin
      unique case (phase_ff)
         2'd0: begin
            mul_x = a_ff[31:0];
            mul_y = b_ff[31:0];
         end
         2'd1: begin
            mul_x = a_ff[31:0];
            mul_y = b_ff[63:32];
         end
         2'd2: begin
            mul_x = a_ff[63:32];
            mul_y = b_ff[31:0];
         end
         2'd3: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      prod_in  = 64'(mul_x) * 64'(mul_y);
      acc_in   = acc_ff;
      phase_in = phase_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         a_in     = a;
         b_in     = b;
         phase_in = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         phase_in = phase_ff + 2'd1;
         if (phase_ff == 2'd1) begin
            acc_in = prod_ff;
         end else if (phase_ff != 2'd0) begin
            acc_in = acc_ff + {prod_ff[31:0], 32'd0};
         end
         if (phase_ff == PH_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (reset) begin
         phase_ff <= '0;
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         run_ff   <= run_in;
         done_ff  <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

   `XXH64_ASSERT_IMPL(a_start_when_free, start, !run_ff && !done_ff)
   `XXH64_ASSERT_NEXT(a_done_after_last, run_ff && (phase_ff == PH_LAST), done_ff && !run_ff)

endmodule

// File: rtl/xxh64_dp.sv
// ----------------------------------------------------------------------------
// xxh64_dp: hash datapath
// Word, length and offset registers, lane accumulators, running hash,
// shared multiplier with operand selection and write-back, result register.
// ----------------------------------------------------------------------------
`include "xxhash_style_hash64_top_defines.svh"

module xxh64_dp
   import xxh64_pkg::*;
#(
   parameter int LENGTH_BITS = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic [63:0] req_data_word,
   input  logic [31:0] req_message_length,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   output logic [63:0] rsp_hash_value
);

   localparam int LEN_W = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
   localparam logic [LEN_W:0] BEAT_BYTES = (LEN_W + 1)'(8);

   logic [63:0]      word_ff, word_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] off_ff, off_in;
   logic [63:0]      h_ff, h_in;
   logic [63:0]      t_ff, t_in;
   logic [63:0]      lane_ff [4];
   logic [63:0]      lane_in [4];
   logic [63:0]      rsp_hash_ff, rsp_hash_in;

   logic [LEN_W-1:0] req_len;
   logic [63:0]      req_len64;
   logic [LEN_W-1:0] chunk_end;
   logic [LEN_W:0]   off_next;
   logic [1:0]       lane_sel;
   logic [63:0]      lane_rd;
   logic [7:0]       byte_val;
   logic [63:0]      merge_sum;
   logic [63:0]      mul_a, mul_b, mul_p;
   logic             mul_done;

   assign req_len   = req_message_length[LEN_W-1:0];
   assign req_len64 = 64'(req_len);
   assign chunk_end = {len_ff[LEN_W-1:5], 5'd0};
   assign off_next  = {1'b0, off_ff} + BEAT_BYTES;

   assign stat.len_zero   = (req_len == '0);
   assign stat.in_chunk   = (off_ff < chunk_end);
   assign stat.whole_word = (off_next <= {1'b0, len_ff});
   assign stat.last_chunk = (off_next == {1'b0, chunk_end});
   assign stat.last_word  = (off_next >= {1'b0, len_ff});
   assign stat.tail_count = len_ff[2:0];
   assign stat.mul_done   = mul_done;

   assign lane_sel = ((cmd.mop == MOP_LANE_A) || (cmd.mop == MOP_LANE_B)) ?
                     off_ff[4:3] : cmd.idx[1:0];
   assign lane_rd  = lane_ff[lane_sel];
   assign byte_val = word_ff[{cmd.idx, 3'b000} +: 8];

   assign merge_sum = rotl64(lane_ff[0], 1) + rotl64(lane_ff[1], 7) +
                      rotl64(lane_ff[2], 12) + rotl64(lane_ff[3], 18);

   always_comb begin
      unique case (cmd.mop)
         MOP_LANE_A: begin mul_a = word_ff;               mul_b = K2; end
         MOP_LANE_B: begin mul_a = t_ff;                  mul_b = K1; end
         MOP_MRG_A:  begin mul_a = lane_rd;               mul_b = K2; end
         MOP_MRG_B:  begin mul_a = t_ff;                  mul_b = K1; end
         MOP_MRG_C:  begin mul_a = h_ff;                  mul_b = K1; end
         MOP_WRD_A:  begin mul_a = word_ff;               mul_b = K2; end
         MOP_WRD_B:  begin mul_a = t_ff;                  mul_b = K1; end
         MOP_WRD_C:  begin mul_a = h_ff;                  mul_b = K1; end
         MOP_BYT_A:  begin mul_a = 64'(byte_val);         mul_b = K5; end
         MOP_BYT_B:  begin mul_a = h_ff;                  mul_b = K1; end
         MOP_AVA_A:  begin mul_a = h_ff ^ (h_ff >> 33);   mul_b = K2; end
         MOP_AVA_B:  begin mul_a = h_ff;                  mul_b = K3; end
         default:    begin mul_a = h_ff;                  mul_b = K1; end
      endcase
   end

   xxh64_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   always_comb begin
      word_in     = word_ff;
      len_in      = len_ff;
      off_in      = off_ff;
      h_in        = h_ff;
      t_in        = t_ff;
      lane_in     = lane_ff;
      rsp_hash_in = rsp_hash_ff;
      if (cmd.capture) begin
         word_in = req_data_word;
      end
      if (cmd.seed) begin
         len_in     = req_len;
         off_in     = '0;
         h_in       = SEED_H + req_len64;
         lane_in[0] = SEED_L0 + req_len64;
         lane_in[1] = SEED_L1 + req_len64;
         lane_in[2] = SEED_L2 + req_len64;
         lane_in[3] = SEED_L3 + req_len64;
      end
      if (cmd.advance) begin
         off_in = off_next[LEN_W-1:0];
      end
      if (cmd.finish) begin
         off_in = '0;
      end
      if (cmd.merge_init) begin
         h_in = merge_sum;
      end
      if (cmd.write_back) begin
         unique case (cmd.mop)
            MOP_LANE_A: t_in = rotl64(lane_rd + mul_p, 31);
            MOP_LANE_B: lane_in[lane_sel] = mul_p;
            MOP_MRG_A:  t_in = rotl64(mul_p, 31);
            MOP_MRG_B:  h_in = h_ff ^ mul_p;
            MOP_MRG_C:  h_in = mul_p + K4;
            MOP_WRD_A:  t_in = rotl64(mul_p, 31);
            MOP_WRD_B:  h_in = rotl64(h_ff ^ mul_p, 27);
            MOP_WRD_C:  h_in = mul_p + K4;
            MOP_BYT_A:  h_in = rotl64(h_ff ^ mul_p, 11);
            MOP_BYT_B:  h_in = mul_p;
            MOP_AVA_A:  h_in = mul_p ^ (mul_p >> 29);
            MOP_AVA_B:  h_in = mul_p ^ (mul_p >> 32);
            default:    h_in = h_ff;
         endcase
      end
      if (cmd.load_rsp) begin
         rsp_hash_in = cmd.rsp_zero ? '0 : h_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      h_ff        <= h_in;
      t_ff        <= t_in;
      lane_ff     <= lane_in;
      rsp_hash_ff <= rsp_hash_in;
      if (reset) begin
         len_ff <= '0;
         off_ff <= '0;
      end else begin
         len_ff <= len_in;
         off_ff <= off_in;
      end
   end

   assign rsp_hash_value = rsp_hash_ff;

   `XXH64_ASSERT_IMPL(a_lane_within_chunks, cmd.write_back && (cmd.mop == MOP_LANE_B), stat.in_chunk)
   `XXH64_ASSERT_IMPL(a_advance_not_last, cmd.advance, !stat.last_word)

endmodule

// File: rtl/xxh64_ctrl.sv
// ----------------------------------------------------------------------------
// xxh64_ctrl: hash sequencer
// Takes one word at a time, steps the datapath through lane, merge, word,
// byte and avalanche multiplies, and owns the result handshake.
// ----------------------------------------------------------------------------
`include "xxhash_style_hash64_top_defines.svh"

module xxh64_ctrl
   import xxh64_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_first_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_DISPATCH = 8'b0000_0010,
      S_ISSUE    = 8'b0000_0100,
      S_WAIT     = 8'b0000_1000,
      S_MERGE    = 8'b0001_0000,
      S_STEP     = 8'b0010_0000,
      S_OUT      = 8'b0100_0000,
      S_ZERO     = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in;
   mop_type    mop_ff, mop_in;
   logic [2:0] idx_ff, idx_in;
   logic       in_msg_ff, in_msg_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      mop_in    = mop_ff;
      idx_in    = idx_ff;
      in_msg_in = in_msg_ff;
      cmd       = '0;
      cmd.mop   = mop_ff;
      cmd.idx   = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               if (req_first_word) begin
                  if (stat.len_zero) begin
                     in_msg_in = 1'b0;
                     state_in  = S_ZERO;
                  end else begin
                     cmd.seed  = 1'b1;
                     in_msg_in = 1'b1;
                     state_in  = S_DISPATCH;
                  end
               end else if (in_msg_ff) begin
                  state_in = S_DISPATCH;
               end
            end
         end
         S_DISPATCH: begin
            priority if (stat.in_chunk) begin
               mop_in = MOP_LANE_A;
            end else if (stat.whole_word) begin
               mop_in = MOP_WRD_A;
            end else begin
               mop_in = MOP_BYT_A;
               idx_in = '0;
            end
            state_in = S_ISSUE;
         end
         S_ISSUE: begin
            cmd.mul_start = 1'b1;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (stat.mul_done) begin
               cmd.write_back = 1'b1;
               state_in       = S_ISSUE;
               unique case (mop_ff)
                  MOP_LANE_A: mop_in = MOP_LANE_B;
                  MOP_LANE_B: state_in = stat.last_chunk ? S_MERGE : S_STEP;
                  MOP_MRG_A:  mop_in = MOP_MRG_B;
                  MOP_MRG_B:  mop_in = MOP_MRG_C;
                  MOP_MRG_C: begin
                     if (idx_ff == LAST_LANE) begin
                        state_in = S_STEP;
                     end else begin
                        idx_in = idx_ff + 3'd1;
                        mop_in = MOP_MRG_A;
                     end
                  end
                  MOP_WRD_A:  mop_in = MOP_WRD_B;
                  MOP_WRD_B:  mop_in = MOP_WRD_C;
                  MOP_WRD_C:  state_in = S_STEP;
                  MOP_BYT_A:  mop_in = MOP_BYT_B;
                  MOP_BYT_B: begin
                     if ((idx_ff + 3'd1) < stat.tail_count) begin
                        idx_in = idx_ff + 3'd1;
                        mop_in = MOP_BYT_A;
                     end else begin
                        state_in = S_STEP;
                     end
                  end
                  MOP_AVA_A:  mop_in = MOP_AVA_B;
                  MOP_AVA_B:  state_in = S_OUT;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_MERGE: begin
            cmd.merge_init = 1'b1;
            mop_in         = MOP_MRG_A;
            idx_in         = '0;
            state_in       = S_ISSUE;
         end
         S_STEP: begin
            if (stat.last_word) begin
               mop_in   = MOP_AVA_A;
               state_in = S_ISSUE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_OUT, S_ZERO: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_zero = (state_ff == S_ZERO);
               cmd.finish   = 1'b1;
               in_msg_in    = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mop_ff       <= MOP_LANE_A;
         idx_ff       <= '0;
         in_msg_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mop_ff       <= mop_in;
         idx_ff       <= idx_in;
         in_msg_ff    <= in_msg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `XXH64_ASSERT_IMPL(a_done_while_waiting, stat.mul_done, state_ff == S_WAIT)
   `XXH64_ASSERT_NEXT(a_result_shown, cmd.load_rsp, rsp_valid_ff)

endmodule

// File: rtl/xxhash_style_hash64_top.sv
// ----------------------------------------------------------------------------
// xxhash_style_hash64_top: streaming 64-bit content hash
// Every 64-bit multiply runs on the one shared 32x32 multiplier. Each word
// runs its lane, whole-word or per-byte multiplies before the next accept;
// the last lane word also runs the merge, and the final word the avalanche.
// A zero-length first word shows 0 without a multiply. Synchronous reset
// returns the block to idle.
// ----------------------------------------------------------------------------
module xxhash_style_hash64_top
   import xxh64_pkg::*;
#(
   parameter int LENGTH_BITS = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_data_word,
   input  logic        req_first_word,
   input  logic [31:0] req_message_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash_value
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   xxh64_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_first_word (req_first_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .stat           (stat),
      .cmd            (cmd)
   );

   xxh64_dp #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_data_word      (req_data_word),
      .req_message_length (req_message_length),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_hash_value     (rsp_hash_value)
   );

endmodule
